// ----- hdl/ray_sphere_intersect_macros.svh -----
// ----------------------------------------------------------------------------
// ray_sphere_intersect_macros.svh
// Assertion macros shared by the ray/sphere intersector.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, register indexes and bundle types of the ray/sphere intersector.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

	localparam int O_W       = 32;   // coordinate
	localparam int D_W       = 18;   // direction component
	localparam int R_W       = 31;   // radius
	localparam int W_W       = 33;   // origin - center
	localparam int A_W       = 36;   // d.d
	localparam int B_W       = 53;   // d.w, signed
	localparam int CC_W      = 67;   // w.w - r*r, signed
	localparam int DISC_W    = 106;  // discriminant, signed
	localparam int RAD_W     = 98;   // nonnegative discriminant bound
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int Q_W       = 54;   // root numerator, signed
	localparam int QMAG_W    = Q_W - 1;
	localparam int QLO_W     = 26;
	localparam int NUM_W     = QMAG_W + D_W;
	localparam int DIV_STEPS = 34;   // quotient bits kept; more saturates anyway
	localparam int DELTA_W   = DIV_STEPS + 1;
	localparam int FRONT_STAGES = 6;
	localparam int BACK_STAGES  = 3;

	typedef enum logic [1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_CENTER_Z = 2'd2,
		CFG_RADIUS   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0][O_W-1:0] center;
		logic [R_W-1:0]      radius;
	} sphere_t;

	typedef struct packed {
		logic [2:0][O_W-1:0] org;
		logic [2:0][D_W-1:0] dir;
		logic [A_W-1:0]      a;
		logic [B_W-1:0]      b;
		logic                ok;
	} side_t;

endpackage

`default_nettype wire

// ----- hdl/rsi_front.sv -----
// ----------------------------------------------------------------------------
// rsi_front
// Six-stage front end: dot products, C, and the discriminant b*b - A*C.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_front (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	input  wire logic [2:0][rsi_pkg::O_W-1:0]            org,
	input  wire logic [2:0][rsi_pkg::D_W-1:0]            dir,
	input  wire rsi_pkg::sphere_t                        sph,
	output logic                                         out_valid,
	output logic [rsi_pkg::RAD_W-1:0]                    rad,
	output rsi_pkg::side_t                               side
);

	localparam int A_W    = rsi_pkg::A_W;
	localparam int B_W    = rsi_pkg::B_W;
	localparam int CC_W   = rsi_pkg::CC_W;
	localparam int DISC_W = rsi_pkg::DISC_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2:0][rsi_pkg::O_W-1:0] org_s1, org_s2, org_s3, org_s4, org_s5;
	logic [2:0][rsi_pkg::D_W-1:0] dir_s1, dir_s2, dir_s3, dir_s4, dir_s5;

	logic signed [rsi_pkg::W_W-1:0] w_s1 [3];
	logic signed [35:0]             dd_s2 [3];
	logic signed [50:0]             dw_s2 [3];
	logic signed [65:0]             ww_s2 [3];
	logic [61:0]                    r2_s2;

	logic [A_W-1:0]         a_s3, a_s4, a_s5;
	logic signed [B_W-1:0]  b_s3, b_s4, b_s5;
	logic signed [CC_W-1:0] cc_s3;

	logic [B_W-2:0]         babs;
	logic [51:0]            bhh_s4, bhl_s4, bll_s4;
	logic signed [70:0]     ach_s4;
	logic [68:0]            acl_s4;

	logic [DISC_W-1:0]      b2_s5, ac_s5;
	logic [DISC_W-1:0]      disc;
	rsi_pkg::side_t         side_s6;
	logic [rsi_pkg::RAD_W-1:0] rad_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	// w = origin - center
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			w_s1[i] <= $signed({org[i][rsi_pkg::O_W-1], org[i]})
				- $signed({sph.center[i][rsi_pkg::O_W-1], sph.center[i]});
		end
		org_s1 <= org;
		dir_s1 <= dir;
	end

	// per-axis products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dd_s2[i] <= $signed(dir_s1[i]) * $signed(dir_s1[i]);
			dw_s2[i] <= $signed(dir_s1[i]) * w_s1[i];
			ww_s2[i] <= w_s1[i] * w_s1[i];
		end
		r2_s2  <= sph.radius * sph.radius;
		org_s2 <= org_s1;
		dir_s2 <= dir_s1;
	end

	// A, b and C
	always_ff @(posedge clk) begin
		a_s3 <= dd_s2[0][A_W-1:0] + dd_s2[1][A_W-1:0] + dd_s2[2][A_W-1:0];
		b_s3 <= B_W'(dw_s2[0]) + B_W'(dw_s2[1]) + B_W'(dw_s2[2]);
		cc_s3 <= CC_W'(ww_s2[0]) + CC_W'(ww_s2[1]) + CC_W'(ww_s2[2])
			- CC_W'({1'b0, r2_s2});
		org_s3 <= org_s2;
		dir_s3 <= dir_s2;
	end

	assign babs = b_s3[B_W-1] ? (B_W-1)'(-b_s3) : (B_W-1)'(b_s3);

	// partial products of b*b and A*C
	always_ff @(posedge clk) begin
		bhh_s4 <= babs[B_W-2:26] * babs[B_W-2:26];
		bhl_s4 <= babs[B_W-2:26] * babs[25:0];
		bll_s4 <= babs[25:0] * babs[25:0];
		ach_s4 <= $signed({1'b0, a_s3}) * $signed(cc_s3[CC_W-1:33]);
		acl_s4 <= a_s3 * cc_s3[32:0];
		a_s4   <= a_s3;
		b_s4   <= b_s3;
		org_s4 <= org_s3;
		dir_s4 <= dir_s3;
	end

	always_ff @(posedge clk) begin
		b2_s5 <= (DISC_W'(bhh_s4) << 52) + (DISC_W'(bhl_s4) << 27) + DISC_W'(bll_s4);
		ac_s5 <= (DISC_W'(ach_s4) << 33) + DISC_W'(acl_s4);
		a_s5   <= a_s4;
		b_s5   <= b_s4;
		org_s5 <= org_s4;
		dir_s5 <= dir_s4;
	end

	assign disc = b2_s5 - ac_s5;

	always_ff @(posedge clk) begin
		rad_s6      <= disc[rsi_pkg::RAD_W-1:0];
		side_s6.org <= org_s5;
		side_s6.dir <= dir_s5;
		side_s6.a   <= a_s5;
		side_s6.b   <= b_s5;
		side_s6.ok  <= (a_s5 != '0) && !disc[DISC_W-1];
	end

	assign out_valid = v_s6;
	assign rad       = rad_s6;
	assign side      = side_s6;

endmodule

`default_nettype wire

// ----- hdl/rsi_sqrt.sv -----
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [rsi_pkg::RAD_W-1:0]     rad,
	input  wire rsi_pkg::side_t                side_in,
	output logic                               out_valid,
	output logic [rsi_pkg::ROOT_W-1:0]         root,
	output rsi_pkg::side_t                     side_out
);

	localparam int N     = rsi_pkg::ROOT_W;
	localparam int RAD_W = rsi_pkg::RAD_W;
	localparam int REM_W = rsi_pkg::REM_W;

	logic                 vld_s  [N+1];
	logic [RAD_W-1:0]     rad_s  [N+1];
	logic [REM_W-1:0]     rem_s  [N+1];
	logic [N-1:0]         root_s [N+1];
	rsi_pkg::side_t       side_s [N+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;

		// bring down two radicand bits, try root*4+1
		assign cur   = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
			side_s[k+1] <= side_s[k];
			if (cur >= trial) begin
				rem_s[k+1]  <= cur - trial;
				root_s[k+1] <= {root_s[k][N-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= cur;
				root_s[k+1] <= {root_s[k][N-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[N];
	assign root      = root_s[N];
	assign side_out  = side_s[N];

endmodule

`default_nettype wire

// ----- hdl/rsi_div.sv -----
// ----------------------------------------------------------------------------
// rsi_div
// One lane of the pipelined restoring divider, capped quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div (
	input  wire logic                          clk,
	input  wire logic [rsi_pkg::NUM_W-1:0]     num,
	input  wire logic [rsi_pkg::A_W-1:0]       den,
	output logic [rsi_pkg::DELTA_W-1:0]        quo
);

	localparam int N     = rsi_pkg::DIV_STEPS;
	localparam int NUM_W = rsi_pkg::NUM_W;
	localparam int A_W   = rsi_pkg::A_W;

	logic [A_W-1:0] rem_s  [N+1];
	logic [N-1:0]   rest_s [N+1];
	logic [A_W-1:0] den_s  [N+1];
	logic [N-1:0]   quo_s  [N+1];
	logic           ovf_s  [N+1];

	// quotient of 2^N or more saturates the hit point regardless
	assign rem_s[0]  = num[A_W+N-1:N];
	assign rest_s[0] = num[N-1:0];
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign ovf_s[0]  = num[NUM_W-1:N] >= (NUM_W-N)'(den);

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [A_W:0] cur;

		assign cur = {rem_s[k], rest_s[k][N-1]};

		always_ff @(posedge clk) begin
			rest_s[k+1] <= {rest_s[k][N-2:0], 1'b0};
			den_s[k+1]  <= den_s[k];
			ovf_s[k+1]  <= ovf_s[k];
			if (cur >= {1'b0, den_s[k]}) begin
				rem_s[k+1] <= A_W'(cur - {1'b0, den_s[k]});
				quo_s[k+1] <= {quo_s[k][N-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= cur[A_W-1:0];
				quo_s[k+1] <= {quo_s[k][N-2:0], 1'b0};
			end
		end
	end

	assign quo = ovf_s[N] ? {1'b1, {N{1'b0}}} : {1'b0, quo_s[N]};

endmodule

`default_nettype wire

// ----- hdl/ray_sphere_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Streams rays against one configured sphere, one ray per clock.
// ----------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   request   start, busy, origin_*, dir_*              in (busy out)
//   result    done, hit_found, hit_x/y/z                out, strobe
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// Every request passes from start to its done strobe through 6 front-end
// stages (dot products and discriminant), 49 square-root stages (one root bit
// each), 3 stages for root choice and the q*d products, 34 divider stages (one
// quotient bit each) and the output register.
// A new request is taken every cycle; busy stays low.
// The receiver cannot stall: each result shows for exactly one cycle.
// arst_n clears valid bits and loads reset values into the sphere registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_sphere_intersect_macros.svh"

module ray_sphere_intersect #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	input  wire logic signed [31:0] origin_z,
	input  wire logic signed [17:0] dir_x,
	input  wire logic signed [17:0] dir_y,
	input  wire logic signed [17:0] dir_z,
	// result
	output logic                    done,
	output logic                    hit_found,
	output logic signed [31:0]      hit_x,
	output logic signed [31:0]      hit_y,
	output logic signed [31:0]      hit_z,
	// configuration
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int O_W     = rsi_pkg::O_W;
	localparam int D_W     = rsi_pkg::D_W;
	localparam int Q_W     = rsi_pkg::Q_W;
	localparam int QMAG_W  = rsi_pkg::QMAG_W;
	localparam int QLO_W   = rsi_pkg::QLO_W;
	localparam int NUM_W   = rsi_pkg::NUM_W;
	localparam int A_W     = rsi_pkg::A_W;
	localparam int N_DIV   = rsi_pkg::DIV_STEPS;
	localparam int SUM_W   = rsi_pkg::DELTA_W + 2;
	localparam int LAT     = rsi_pkg::FRONT_STAGES + rsi_pkg::ROOT_W
		+ rsi_pkg::BACK_STAGES + N_DIV + 1;

	typedef struct packed {
		logic [2:0][O_W-1:0] org;
		logic [2:0]          neg;
		logic                hit;
	} tail_t;

	// ------------------------------------------------------------------
	// configuration registers, unchecked by the block: the user writes them only while the pipe is empty
	// ------------------------------------------------------------------
	rsi_pkg::sphere_t sph_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sph_q.center <= '0;
			sph_q.radius <= rsi_pkg::R_W'(64'd1 << FRAC_BITS);
		end else if (cfg_valid && cfg_ready) begin
			case (rsi_pkg::cfg_idx_t'(cfg_index))
				rsi_pkg::CFG_CENTER_X: sph_q.center[0] <= cfg_data;
				rsi_pkg::CFG_CENTER_Y: sph_q.center[1] <= cfg_data;
				rsi_pkg::CFG_CENTER_Z: sph_q.center[2] <= cfg_data;
				rsi_pkg::CFG_RADIUS:   sph_q.radius <= cfg_data[rsi_pkg::R_W-1:0];
				default:               sph_q <= sph_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// front end and square root
	// ------------------------------------------------------------------
	logic                         fr_valid;
	logic [rsi_pkg::RAD_W-1:0]    fr_rad;
	rsi_pkg::side_t               fr_side;
	logic                         sq_valid;
	logic [rsi_pkg::ROOT_W-1:0]   sq_root;
	rsi_pkg::side_t               sq_side;

	rsi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.org       ({origin_z, origin_y, origin_x}),
		.dir       ({dir_z, dir_y, dir_x}),
		.sph       (sph_q),
		.out_valid (fr_valid),
		.rad       (fr_rad),
		.side      (fr_side)
	);

	rsi_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.rad       (fr_rad),
		.side_in   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	// ------------------------------------------------------------------
	// root choice: q1 = -b - s, q2 = -b + s
	// ------------------------------------------------------------------
	logic signed [Q_W-1:0] nb, sroot, q1, q2, qsel;
	logic                  q1_pos, q2_neg;

	assign nb     = -Q_W'($signed(sq_side.b));
	assign sroot  = $signed(Q_W'(sq_root));
	assign q1     = nb - sroot;
	assign q2     = nb + sroot;
	assign q1_pos = !q1[Q_W-1] && (q1 != '0);
	assign q2_neg = q2[Q_W-1];
	// nearer root when both are ahead, far root when the origin is inside
	assign qsel   = q1_pos ? q1 : q2;

	logic                   v_s1, v_s2, v_s3;
	logic [QMAG_W-1:0]      qmag_s1;
	logic [2:0][D_W-1:0]    dmag_s1;
	tail_t                  tail_s1, tail_s2, tail_s3;
	logic [A_W-1:0]         den_s1, den_s2, den_s3;
	logic [QMAG_W-QLO_W+D_W-1:0] ph_s2 [3];
	logic [QLO_W+D_W-1:0]   pl_s2 [3];
	logic [NUM_W-1:0]       num_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= sq_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// step direction per axis: sign of q times sign of d
	always_ff @(posedge clk) begin
		qmag_s1     <= qsel[Q_W-1] ? QMAG_W'(-qsel) : QMAG_W'(qsel);
		tail_s1.org <= sq_side.org;
		tail_s1.hit <= sq_side.ok && (q1_pos || !q2_neg);
		den_s1      <= sq_side.a;
		for (int i = 0; i < 3; i++) begin
			tail_s1.neg[i] <= qsel[Q_W-1] ^ sq_side.dir[i][D_W-1];
			dmag_s1[i] <= sq_side.dir[i][D_W-1] ? D_W'(-$signed(sq_side.dir[i]))
				: sq_side.dir[i];
		end
	end

	// split |q| * |d| into two products per axis
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ph_s2[i] <= qmag_s1[QMAG_W-1:QLO_W] * dmag_s1[i];
			pl_s2[i] <= qmag_s1[QLO_W-1:0] * dmag_s1[i];
		end
		tail_s2 <= tail_s1;
		den_s2  <= den_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s3[i] <= (NUM_W'(ph_s2[i]) << QLO_W) + NUM_W'(pl_s2[i]);
		end
		tail_s3 <= tail_s2;
		den_s3  <= den_s2;
	end

	// ------------------------------------------------------------------
	// dividers: delta = trunc(|q|*|d| / A), one lane per axis
	// ------------------------------------------------------------------
	logic [rsi_pkg::DELTA_W-1:0] delta [3];

	for (genvar g = 0; g < 3; g++) begin : g_lane
		rsi_div u_div (
			.clk (clk),
			.num (num_s3[g]),
			.den (den_s3),
			.quo (delta[g])
		);
	end

	// carry the rest of the request alongside the divider
	logic  dv_s   [N_DIV+1];
	tail_t dt_s   [N_DIV+1];

	assign dv_s[0] = v_s3;
	assign dt_s[0] = tail_s3;

	for (genvar k = 0; k < N_DIV; k++) begin : g_tail
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else begin
				dv_s[k+1] <= dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dt_s[k+1] <= dt_s[k];
		end
	end

	// ------------------------------------------------------------------
	// hit point = origin +/- delta, saturated; zero when missed
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0] sum [3];
	logic [O_W-1:0]          sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = dt_s[N_DIV].neg[i]
				? SUM_W'($signed(dt_s[N_DIV].org[i])) - $signed(SUM_W'(delta[i]))
				: SUM_W'($signed(dt_s[N_DIV].org[i])) + $signed(SUM_W'(delta[i]));
			if (!sum[i][SUM_W-1] && (sum[i][SUM_W-2:O_W-1] != '0)) begin
				sat[i] = {1'b0, {(O_W-1){1'b1}}};
			end else if (sum[i][SUM_W-1] && (sum[i][SUM_W-2:O_W-1] != '1)) begin
				sat[i] = {1'b1, {(O_W-1){1'b0}}};
			end else begin
				sat[i] = sum[i][O_W-1:0];
			end
		end
	end

	logic           done_q;
	logic           hit_q;
	logic [O_W-1:0] hx_q, hy_q, hz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_s[N_DIV];
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= dt_s[N_DIV].hit;
		hx_q  <= dt_s[N_DIV].hit ? sat[0] : '0;
		hy_q  <= dt_s[N_DIV].hit ? sat[1] : '0;
		hz_q  <= dt_s[N_DIV].hit ? sat[2] : '0;
	end

	assign done      = done_q;
	assign hit_found = hit_q;
	assign hit_x     = hx_q;
	assign hit_y     = hy_q;
	assign hit_z     = hz_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`RSI_ASSERT_IMP(a_latency, start && !busy, ##LAT done, "request lost in pipe")
	`RSI_ASSERT_IMP(a_source, done, $past(start && !busy, LAT), "result without request")
	`RSI_ASSERT_IMP(a_miss_zero, done && !hit_found, (hit_x | hit_y | hit_z) == '0, "miss point")
	`RSI_ASSERT_NXT(a_zero_dir, sq_valid && sq_side.a == '0, !tail_s1.hit, "hit with zero direction")

endmodule

`default_nettype wire
